/* rtl/core/sacfw_pkg.sv */
//------------------------------------------------------------------------------
// sacfw_pkg
// Shared types and constants of the set-associative write-back cache.
//------------------------------------------------------------------------------
`default_nettype none
package sacfw_pkg;
   localparam int CMD_W   = 1;
   localparam int ADDR_W  = 7;
   localparam int CNT_W   = 16;
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Cache geometry; the response field widths are fixed and do not follow these.
   localparam int NUM_SETS   = 2;
   localparam int NUM_WAYS   = 4;
   localparam int LINE_WORDS = 4;
   localparam int MEM_BLOCKS = 32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request and look up the tags
      logic wb_word;   // copy one cache word to the backing memory
      logic fill_word; // copy one backing memory word into the cache
      logic install;   // update tag, valid and dirty, advance the pointer
      logic finish;    // apply the access and present the result
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;
      logic victim_dirty;
      logic last_word;
      logic init;      // backing memory load after reset still running
   } stat_type;
endpackage
`default_nettype wire

/* rtl/core/sacfw_ctrl.sv */
//------------------------------------------------------------------------------
// sacfw_ctrl
// Controller: sequences lookup, write-back, fill and completion of one access.
//------------------------------------------------------------------------------
`default_nettype none
module sacfw_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   output sacfw_pkg::ctrl_type     ctrl,
   input  wire sacfw_pkg::stat_type stat
);
   import sacfw_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOK   = 3'd1;
   localparam logic [2:0] ST_WB     = 3'd2;
   localparam logic [2:0] ST_FILL   = 3'd3;
   localparam logic [2:0] ST_INST   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !stat.init) begin
               ctrl.capture = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (stat.hit) state_in = ST_DONE;
            else if (stat.victim_dirty) state_in = ST_WB;
            else state_in = ST_FILL;
         end
         ST_WB: begin
            ctrl.wb_word = 1'b1;
            if (stat.last_word) state_in = ST_FILL;
         end
         ST_FILL: begin
            ctrl.fill_word = 1'b1;
            if (stat.last_word) state_in = ST_INST;
         end
         ST_INST: begin
            ctrl.install = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            ctrl.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE) || stat.init;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({ctrl.wb_word, ctrl.fill_word, ctrl.install, ctrl.finish}) <= 1)
      else $error("controller issued two commands at once");
   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && stat.hit) |=> ctrl.finish)
      else $error("hit did not complete next cycle");
   a_fill_inst: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fill_word && stat.last_word) |=> ctrl.install)
      else $error("fill not followed by install");
endmodule
`default_nettype wire

/* rtl/core/sacfw_dp.sv */
//------------------------------------------------------------------------------
// sacfw_dp
// Datapath: tags, line store, backing memory, FIFO pointers and counters.
//------------------------------------------------------------------------------
`default_nettype none
module sacfw_dp #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sacfw_pkg::ctrl_type           ctrl,
   output sacfw_pkg::stat_type                stat,
   input  wire logic                          req_cmd,
   input  wire logic [sacfw_pkg::ADDR_W-1:0]  req_address,
   input  wire logic [DATA_WIDTH-1:0]         req_write_data,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [DATA_WIDTH-1:0]              rsp_read_data,
   output logic [2:0]                         rsp_line_index,
   output logic                               rsp_set_index,
   output logic [1:0]                         rsp_word_offset,
   output logic                               rsp_wrote_back,
   output logic [sacfw_pkg::CNT_W-1:0]        rsp_read_count,
   output logic [sacfw_pkg::CNT_W-1:0]        rsp_read_miss_count,
   output logic [sacfw_pkg::CNT_W-1:0]        rsp_write_count,
   output logic [sacfw_pkg::CNT_W-1:0]        rsp_write_miss_count
);
   import sacfw_pkg::*;

   localparam int OFF_W  = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
   localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int LINES  = NUM_SETS * NUM_WAYS;
   localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int BLK_W  = $clog2(MEM_BLOCKS);
   localparam int MEM_WORDS = MEM_BLOCKS * LINE_WORDS;
   localparam int MADDR_W = $clog2(MEM_WORDS);
   localparam int CADDR_W = LINE_W + OFF_W;
   localparam int OFF_BITS = $clog2(LINE_WORDS);
   localparam int SET_BITS = $clog2(NUM_SETS);
   localparam int TAG_W  = (ADDR_W - OFF_BITS - SET_BITS > 0) ?
                           ADDR_W - OFF_BITS - SET_BITS : 1;
   localparam int WCNT_W = OFF_W + 1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Request registers.
   logic                  cmd_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [DATA_WIDTH-1:0] wdata_ff;

   logic [OFF_W-1:0] offset;
   logic [SET_W-1:0] set_sel;
   logic [TAG_W-1:0] tag;
   logic [BLK_W-1:0] block;
   logic [ADDR_W-1:0] blk_full;

   assign offset   = OFF_W'(addr_ff % LINE_WORDS);
   assign blk_full = ADDR_W'(addr_ff / LINE_WORDS);
   assign set_sel  = SET_W'(blk_full % NUM_SETS);
   assign tag      = TAG_W'(addr_ff / (LINE_WORDS * NUM_SETS));
   assign block    = BLK_W'(blk_full % MEM_BLOCKS);

   // Tag state, one entry per line, and one FIFO pointer per set.
   logic [TAG_W-1:0]  tag_ff   [LINES];
   logic [LINES-1:0]  valid_ff;
   logic [LINES-1:0]  dirty_ff;
   logic [WAY_W-1:0]  fifo_ff  [NUM_SETS];

   // Lookup result, registered in the cycle after capture.
   logic             hit_ff;
   logic [WAY_W-1:0] way_ff;
   logic             wb_ff;
   logic [LINE_W-1:0] line;

   logic             look_hit;
   logic [WAY_W-1:0] look_way;
   always_comb begin
      look_hit = 1'b0;
      look_way = fifo_ff[set_sel];
      for (int k = NUM_WAYS - 1; k >= 0; k--) begin
         if (valid_ff[LINE_W'(set_sel * NUM_WAYS + k)] &&
             tag_ff[LINE_W'(set_sel * NUM_WAYS + k)] == tag) begin
            look_hit = 1'b1;
            look_way = WAY_W'(k);
         end
      end
   end

   // In the lookup cycle the controller decides on the live tag compare.
   logic             look_ff;
   logic [WAY_W-1:0] way_cur;
   assign way_cur = look_ff ? look_way : way_ff;
   assign line = LINE_W'(set_sel * NUM_WAYS + way_cur);

   // Word counter for write-back and fill; memories are read a word ahead of the writes.
   logic [WCNT_W-1:0] wcnt_ff;
   logic [OFF_W-1:0]  widx;
   assign widx = wcnt_ff[OFF_W-1:0];
   assign stat.last_word = (wcnt_ff == WCNT_W'(LINE_WORDS));
   assign stat.hit = look_ff ? look_hit : hit_ff;
   assign stat.victim_dirty = valid_ff[line] && dirty_ff[line];

   logic [BLK_W-1:0] vblock;
   assign vblock = BLK_W'((tag_ff[line] * NUM_SETS + set_sel) % MEM_BLOCKS);

   // Line store and backing memory.
   logic [DATA_WIDTH-1:0] cache_mem [LINES*LINE_WORDS];
   logic [DATA_WIDTH-1:0] back_mem  [MEM_WORDS];
   logic [DATA_WIDTH-1:0] cache_rd_ff, back_rd_ff;
   logic [CADDR_W-1:0]    cache_ra, cache_wa;
   logic [MADDR_W-1:0]    back_ra, back_wa;
   logic                  cache_we, back_we;
   logic [DATA_WIDTH-1:0] cache_wd;
   logic [OFF_W-1:0]      prev_idx;

   // Reset of the backing memory: a sweep that loads a+1 into word a.
   logic [MADDR_W:0] init_ff;
   logic             init_busy;
   assign init_busy = (init_ff != (MADDR_W+1)'(MEM_WORDS));
   assign stat.init = init_busy;

   assign prev_idx = OFF_W'(wcnt_ff - 1'b1);
   always_comb begin
      cache_ra = {line, widx};
      back_ra  = {block, widx};
      cache_we = 1'b0;
      cache_wa = {line, prev_idx};
      cache_wd = back_rd_ff;
      back_we  = 1'b0;
      back_wa  = {vblock, prev_idx};
      if (ctrl.fill_word && wcnt_ff != '0) cache_we = 1'b1;
      if (ctrl.wb_word && wcnt_ff != '0) back_we = 1'b1;
      if (ctrl.finish) begin
         cache_ra = {line, offset};
         if (cmd_ff == CMD_WRITE) begin
            cache_we = 1'b1;
            cache_wa = {line, offset};
            cache_wd = wdata_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cache_we) cache_mem[cache_wa] <= cache_wd;
      cache_rd_ff <= cache_mem[cache_ra];
      if (init_busy) back_mem[init_ff[MADDR_W-1:0]] <=
         DATA_WIDTH'(init_ff[MADDR_W-1:0]) + 1'b1;
      else if (back_we) back_mem[back_wa] <= cache_rd_ff;
      back_rd_ff <= back_mem[back_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) init_ff <= '0;
      else if (init_busy) init_ff <= init_ff + 1'b1;
   end

   // Counters.
   logic [CNT_W-1:0] rc_ff, rmc_ff, wc_ff, wmc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff   <= req_cmd;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
      end
      if (look_ff) begin
         hit_ff <= look_hit;
         way_ff <= look_way;
      end
      if (ctrl.wb_word || ctrl.fill_word) begin
         wcnt_ff <= stat.last_word ? '0 : wcnt_ff + 1'b1;
      end else begin
         wcnt_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         dirty_ff  <= '0;
         look_ff   <= 1'b0;
         wb_ff     <= 1'b0;
         rsp_valid <= 1'b0;
         rc_ff <= '0; rmc_ff <= '0; wc_ff <= '0; wmc_ff <= '0;
         for (int s = 0; s < NUM_SETS; s++) fifo_ff[s] <= '0;
         for (int l = 0; l < LINES; l++) tag_ff[l] <= '0;
      end else begin
         look_ff   <= ctrl.capture;
         rsp_valid <= 1'b0;
         if (ctrl.capture) wb_ff <= 1'b0;
         if (ctrl.wb_word) wb_ff <= 1'b1;
         if (ctrl.install) begin
            tag_ff[line]   <= tag;
            valid_ff[line] <= 1'b1;
            dirty_ff[line] <= 1'b0;
            fifo_ff[set_sel] <= WAY_W'((way_ff + 1'b1) % NUM_WAYS);
         end
         if (ctrl.finish) begin
            rsp_valid <= 1'b1;
            if (cmd_ff == CMD_WRITE) begin
               dirty_ff[line] <= 1'b1;
               if (wc_ff != CNT_MAX) wc_ff <= wc_ff + 1'b1;
               if (!hit_ff && wmc_ff != CNT_MAX) wmc_ff <= wmc_ff + 1'b1;
            end else begin
               if (rc_ff != CNT_MAX) rc_ff <= rc_ff + 1'b1;
               if (!hit_ff && rmc_ff != CNT_MAX) rmc_ff <= rmc_ff + 1'b1;
            end
         end
      end
   end

   // Response fields stay in registers; read data appears with the strobe.
   logic [2:0] line_out_ff;
   logic [1:0] off_out_ff;
   logic       set_out_ff, hit_out_ff, wb_out_ff;
   logic [DATA_WIDTH-1:0] wdata_out_ff;
   logic       wr_out_ff;
   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         line_out_ff  <= 3'(line);
         off_out_ff   <= 2'(offset);
         set_out_ff   <= 1'(set_sel);
         hit_out_ff   <= hit_ff;
         wb_out_ff    <= wb_ff;
         wr_out_ff    <= cmd_ff;
         wdata_out_ff <= wdata_ff;
      end
   end

   assign rsp_hit         = hit_out_ff;
   assign rsp_read_data   = wr_out_ff ? wdata_out_ff : cache_rd_ff;
   assign rsp_line_index  = line_out_ff;
   assign rsp_set_index   = set_out_ff;
   assign rsp_word_offset = off_out_ff;
   assign rsp_wrote_back  = wb_out_ff;
   assign rsp_read_count       = rc_ff;
   assign rsp_read_miss_count  = rmc_ff;
   assign rsp_write_count      = wc_ff;
   assign rsp_write_miss_count = wmc_ff;

   a_wb_dirty: assert property (@(posedge clock) disable iff (reset)
      (ctrl.wb_word && wcnt_ff == '0) |-> stat.victim_dirty)
      else $error("write-back of a clean line");
   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.install |=> valid_ff[$past(line)])
      else $error("installed line not valid");
   a_hit_nowb: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_wrote_back)
      else $error("write-back reported on a hit");
endmodule
`default_nettype wire

/* rtl/core/set_assoc_cache_fifo_writeback.sv */
//------------------------------------------------------------------------------
// set_assoc_cache_fifo_writeback
// Two-set, four-way write-back cache with FIFO replacement and internal memory.
//------------------------------------------------------------------------------
// A word is accepted when start is high and busy is low. A miss takes longer
// than a hit, and a dirty miss longer than a clean one, since the backing
// memory moves a line one word per cycle through its word-wide ports. After
// reset busy stays high while all MEM_BLOCKS*LINE_WORDS words (128 by default)
// of the backing memory are loaded. Results are shown for one cycle only and
// must be captured then.
`default_nettype none
module set_assoc_cache_fifo_writeback #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_cmd,
   input  wire logic [sacfw_pkg::ADDR_W-1:0]  req_address,
   input  wire logic [DATA_WIDTH-1:0]         req_write_data,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [DATA_WIDTH-1:0]              rsp_read_data,
   output logic [2:0]                         rsp_line_index,
   output logic                               rsp_set_index,
   output logic [1:0]                         rsp_word_offset,
   output logic                               rsp_wrote_back,
   output logic [sacfw_pkg::CNT_W-1:0]        rsp_read_count,
   output logic [sacfw_pkg::CNT_W-1:0]        rsp_read_miss_count,
   output logic [sacfw_pkg::CNT_W-1:0]        rsp_write_count,
   output logic [sacfw_pkg::CNT_W-1:0]        rsp_write_miss_count
);
   import sacfw_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   sacfw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   sacfw_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .ctrl                 (ctrl),
      .stat                 (stat),
      .req_cmd              (req_cmd),
      .req_address          (req_address),
      .req_write_data       (req_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_hit              (rsp_hit),
      .rsp_read_data        (rsp_read_data),
      .rsp_line_index       (rsp_line_index),
      .rsp_set_index        (rsp_set_index),
      .rsp_word_offset      (rsp_word_offset),
      .rsp_wrote_back       (rsp_wrote_back),
      .rsp_read_count       (rsp_read_count),
      .rsp_read_miss_count  (rsp_read_miss_count),
      .rsp_write_count      (rsp_write_count),
      .rsp_write_miss_count (rsp_write_miss_count)
   );
endmodule
`default_nettype wire

/* tb/sacfw_checker.sv */
//------------------------------------------------------------------------------
// sacfw_checker
// Watches the request and response channels of the cache, predicts every
// response from its own copy of tags, lines, FIFO pointers, memory and
// counters, and compares each response field by field.
//------------------------------------------------------------------------------
module sacfw_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_cmd,
   input  logic [6:0]  req_address,
   input  logic [31:0] req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_hit,
   input  logic [31:0] rsp_read_data,
   input  logic [2:0]  rsp_line_index,
   input  logic        rsp_set_index,
   input  logic [1:0]  rsp_word_offset,
   input  logic        rsp_wrote_back,
   input  logic [15:0] rsp_read_count,
   input  logic [15:0] rsp_read_miss_count,
   input  logic [15:0] rsp_write_count,
   input  logic [15:0] rsp_write_miss_count,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sacfw_pkg::*;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_data;
      logic [2:0]  line_index;
      logic        set_index;
      logic [1:0]  word_offset;
      logic        wrote_back;
      logic [15:0] rd_cnt;
      logic [15:0] rd_miss_cnt;
      logic [15:0] wr_cnt;
      logic [15:0] wr_miss_cnt;
   } access_result_type;

   access_result_type expected_q[$];

   logic [3:0]  tags[8];
   logic        valid[8];
   logic        dirty[8];
   logic [31:0] words[32];
   logic [1:0]  victim_ptr[2];
   logic [31:0] memory[128];
   logic [15:0] counts[4];

   function automatic logic [15:0] sat_inc(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   task automatic predict_access(logic cmd, logic [6:0] addr, logic [31:0] wdata);
      access_result_type r;
      logic [1:0] ofs;
      logic       set;
      logic [3:0] tag;
      logic [4:0] blk;
      logic [4:0] vblk;
      logic [1:0] way;
      logic [2:0] ln;
      logic       found;
      ofs = addr[1:0];
      set = addr[2];
      tag = addr[6:3];
      blk = addr[6:2];
      way = 2'd0;
      found = 1'b0;
      r = '0;
      for (int k = 3; k >= 0; k--)
         if (valid[set*4+k] && tags[set*4+k] == tag) begin
            found = 1'b1;
            way = 2'(k);
         end
      if (!found) begin
         way = victim_ptr[set];
         victim_ptr[set] = way + 2'd1;
         ln = {set, way};
         if (valid[ln] && dirty[ln]) begin
            vblk = {tags[ln], set};
            for (int k = 0; k < 4; k++) memory[vblk*4+k] = words[ln*4+k];
            r.wrote_back = 1'b1;
         end
         for (int k = 0; k < 4; k++) words[ln*4+k] = memory[blk*4+k];
         tags[ln] = tag;
         valid[ln] = 1'b1;
         dirty[ln] = 1'b0;
      end
      ln = {set, way};
      if (cmd == CMD_WRITE) begin
         words[ln*4+ofs] = wdata;
         dirty[ln] = 1'b1;
         counts[2] = sat_inc(counts[2]);
         if (!found) counts[3] = sat_inc(counts[3]);
      end else begin
         counts[0] = sat_inc(counts[0]);
         if (!found) counts[1] = sat_inc(counts[1]);
      end
      r.hit = found;
      r.read_data = words[ln*4+ofs];
      r.line_index = ln;
      r.set_index = set;
      r.word_offset = ofs;
      r.rd_cnt = counts[0];
      r.rd_miss_cnt = counts[1];
      r.wr_cnt = counts[2];
      r.wr_miss_cnt = counts[3];
      expected_q.push_back(r);
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      access_result_type e;
      if (reset) begin
         expected_q.delete();
         for (int i = 0; i < 8; i++) begin
            tags[i] = 4'd0;
            valid[i] = 1'b0;
            dirty[i] = 1'b0;
         end
         for (int i = 0; i < 32; i++) words[i] = 32'd0;
         victim_ptr[0] = 2'd0;
         victim_ptr[1] = 2'd0;
         for (int i = 0; i < 128; i++) memory[i] = 32'(i + 1);
         for (int i = 0; i < 4; i++) counts[i] = 16'd0;
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report("unexpected word", 32'd0, 32'd0);
            end else begin
               e = expected_q.pop_front();
               if (rsp_hit !== e.hit) report("hit", 32'(rsp_hit), 32'(e.hit));
               if (rsp_read_data !== e.read_data)
                  report("read_data", rsp_read_data, e.read_data);
               if (rsp_line_index !== e.line_index)
                  report("line_index", 32'(rsp_line_index), 32'(e.line_index));
               if (rsp_set_index !== e.set_index)
                  report("set_index", 32'(rsp_set_index), 32'(e.set_index));
               if (rsp_word_offset !== e.word_offset)
                  report("word_offset", 32'(rsp_word_offset), 32'(e.word_offset));
               if (rsp_wrote_back !== e.wrote_back)
                  report("wrote_back", 32'(rsp_wrote_back), 32'(e.wrote_back));
               if (rsp_read_count !== e.rd_cnt)
                  report("read_count", 32'(rsp_read_count), 32'(e.rd_cnt));
               if (rsp_read_miss_count !== e.rd_miss_cnt)
                  report("read_miss_count", 32'(rsp_read_miss_count),
                         32'(e.rd_miss_cnt));
               if (rsp_write_count !== e.wr_cnt)
                  report("write_count", 32'(rsp_write_count), 32'(e.wr_cnt));
               if (rsp_write_miss_count !== e.wr_miss_cnt)
                  report("write_miss_count", 32'(rsp_write_miss_count),
                         32'(e.wr_miss_cnt));
            end
         end
         // The request is predicted after the response check of the same edge.
         if (start && !busy) predict_access(req_cmd, req_address, req_write_data);
      end
      pending_count = expected_q.size();
   end
endmodule

/* tb/tb_set_assoc_cache_fifo_writeback.sv */
//------------------------------------------------------------------------------
// tb_set_assoc_cache_fifo_writeback
// Drives directed and random read and write accesses with random gaps into
// the cache and reports the checker's verdict.
//------------------------------------------------------------------------------
module tb_set_assoc_cache_fifo_writeback;
   timeunit 1ns;
   timeprecision 1ps;
   import sacfw_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_cmd = 0;
   logic [6:0]  req_address = 0;
   logic [31:0] req_write_data = 0;
   logic        rsp_valid, rsp_hit, rsp_set_index, rsp_wrote_back;
   logic [31:0] rsp_read_data;
   logic [2:0]  rsp_line_index;
   logic [1:0]  rsp_word_offset;
   logic [15:0] rsp_read_count, rsp_read_miss_count, rsp_write_count;
   logic [15:0] rsp_write_miss_count;
   int          fail_count, pending_count;
   int          cycle_count = 0;

   always #6 clock = ~clock;

   set_assoc_cache_fifo_writeback uut (.*);
   sacfw_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The cache is busy after each accepted word, so the falling edge spent on
   // dropping start never costs throughput.
   task automatic send_access(logic cmd, logic [6:0] addr, logic [31:0] wdata);
      int gap;
      gap = $urandom_range(0, 8);
      repeat (gap + 1) @(negedge clock);
      req_cmd <= cmd;
      req_address <= addr;
      req_write_data <= wdata;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start <= 0;
   endtask

   initial begin
      logic [6:0] base;
      repeat (6) @(negedge clock);
      reset <= 0;
      // Directed: extremes, a hit after a miss, then six dirty tags in one set
      // so the FIFO pointer wraps and dirty victims are written back.
      send_access(CMD_READ, 7'd0, 0);
      send_access(CMD_READ, 7'd3, 0);
      send_access(CMD_WRITE, 7'd127, 32'hFFFFFFFF);
      send_access(CMD_READ, 7'd127, 0);
      send_access(CMD_WRITE, 7'd124, 32'h0);
      for (int t = 0; t < 6; t++)
         send_access(CMD_WRITE, {t[3:0], 1'b0, 2'd1}, 32'hA5A50000 + t);
      for (int t = 0; t < 6; t++)
         send_access(CMD_READ, {t[3:0], 1'b0, 2'd1}, 0);
      send_access(CMD_WRITE, 7'd5, 32'h5A5A5A5A);
      // Hold off until every pending word has been checked.
      while (pending_count != 0) @(negedge clock);
      for (int i = 0; i < 800; i++) begin
         if ($urandom_range(0, 3) == 0)
            base = 7'($urandom_range(0, 127));
         else // mostly a few tags so hits and conflicts both occur
            base = {1'b0, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))};
         send_access(1'($urandom_range(0, 1)), base, $urandom);
         if (i == 400)
            while (pending_count != 0) @(negedge clock);
      end
      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
